// ===== rtl/chmt_pkg.sv =====
// Package for the ChaCha-style memory-test pattern checker.
// Field widths, lane constants, quarter-round tables and the round-step function.
// No dependencies.
`timescale 1ns / 1ps

package chmt_pkg;

    // Field widths
    localparam int unsigned BLOCK_W = 5;
    localparam int unsigned WORD_W  = 24;
    localparam int unsigned DATA_W  = 64;
    localparam int unsigned LANES   = 16;
    localparam int unsigned LANE_W  = 4;

    // One round step per stage: 4 quarter-round layers of 6 steps each
    localparam int unsigned STEPS_PER_QR = 6;
    localparam int unsigned NUM_LAYERS   = 4;
    localparam int unsigned NUM_STAGES   = STEPS_PER_QR * NUM_LAYERS;

    // Fixed lane constants of the initial state
    localparam logic [DATA_W-1:0] LANE_C0 = 64'h0000_0000_6578_7062;
    localparam logic [DATA_W-1:0] LANE_C1 = 64'h0000_0000_6e64_2033;
    localparam logic [DATA_W-1:0] LANE_C2 = 64'h0000_0000_322d_6279;
    localparam logic [DATA_W-1:0] LANE_C3 = 64'h0000_0000_7465_206b;
    localparam logic [DATA_W-1:0] LANE_C4 = 64'h0000_0000_6579_0000;

    // Quarter-round lane sets: rows first, then diagonals; each entry is {a, b, c, d}
    localparam logic [LANE_W-1:0] QR_IDX [8][4] = '{
        '{4'd0,  4'd1,  4'd2,  4'd3},
        '{4'd4,  4'd5,  4'd6,  4'd7},
        '{4'd8,  4'd9,  4'd10, 4'd11},
        '{4'd12, 4'd13, 4'd14, 4'd15},
        '{4'd0,  4'd5,  4'd10, 4'd15},
        '{4'd1,  4'd6,  4'd11, 4'd12},
        '{4'd2,  4'd7,  4'd8,  4'd13},
        '{4'd3,  4'd4,  4'd9,  4'd14}
    };

    // Rotate-right amount of each step inside a quarter round
    localparam int unsigned ROT_AMT [STEPS_PER_QR] = '{32, 24, 16, 12, 8, 7};

    typedef logic [LANES-1:0][DATA_W-1:0] t_state;

    // Per-transaction sideband that travels with the state
    typedef struct packed {
        logic              action;
        logic              skip;
        logic [LANE_W-1:0] lane;
        logic [DATA_W-1:0] read_data;
    } t_side;

    function automatic logic [DATA_W-1:0] rotr64(logic [DATA_W-1:0] x, int unsigned r);
        rotr64 = (x >> r) | (x << (DATA_W - r));
    endfunction

    // One add/xor/rotate step applied to all four quarter rounds of a layer.
    // diag selects the diagonal layer, kk the step inside the quarter round.
    // Both are constants at each call site, so this is fixed wiring plus four adders.
    function automatic t_state qr_step(t_state v, logic diag, int unsigned kk);
        t_state            r;
        logic [LANE_W-1:0] a;
        logic [LANE_W-1:0] b;
        logic [LANE_W-1:0] c;
        logic [LANE_W-1:0] d;
        r = v;
        for (int q = 0; q < 4; q++) begin
            a = QR_IDX[{diag, 2'(q)}][0];
            b = QR_IDX[{diag, 2'(q)}][1];
            c = QR_IDX[{diag, 2'(q)}][2];
            d = QR_IDX[{diag, 2'(q)}][3];
            if ((kk & 1) == 0) begin
                r[a] = r[a] + r[b];
                r[d] = rotr64(r[d] ^ r[a], ROT_AMT[kk]);
            end else begin
                r[c] = r[c] + r[d];
                r[b] = rotr64(r[b] ^ r[c], ROT_AMT[kk]);
            end
        end
        return r;
    endfunction

endpackage

// ===== rtl/chmt_ifs.sv =====
// Valid/ready channel interfaces of the pattern checker: beat in, result out.
// Depends on chmt_pkg for the field widths.
`timescale 1ns / 1ps

interface chmt_in_if import chmt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              action;
    logic [BLOCK_W-1:0] block_index;
    logic [WORD_W-1:0]  word_index;
    logic [DATA_W-1:0]  read_data;

    modport source (output valid, action, block_index, word_index, read_data, input ready);
    modport sink   (input valid, action, block_index, word_index, read_data, output ready);
endinterface

interface chmt_out_if import chmt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] pattern_word;
    logic              mismatch;
    logic              skipped;

    modport source (output valid, pattern_word, mismatch, skipped, input ready);
    modport sink   (input valid, pattern_word, mismatch, skipped, output ready);
endinterface

// ===== rtl/chacha_memtest_pattern_checker.sv =====
// Top level of the ChaCha-style memory-test pattern checker.
// Depends on chmt_pkg and the channel interfaces in chmt_ifs.sv.
`timescale 1ns / 1ps

// Takes one memory beat (action, block, word, read data) per cycle and returns
// one result per beat, in order: the 64-bit pattern for lane (word mod 16) of
// the block, a mismatch flag when checking, and a skip flag for words 0 to 15
// of block 0 (pattern and mismatch are then 0). Throughput is one transaction
// per cycle; a beat passes 24 pipeline stages, each one 64-bit add/xor/rotate
// step of the two double rounds (four quarter rounds in parallel per stage),
// then the output register holding the lane select and compare. A stall on
// the output holds the whole pipeline. The salt is sampled as each beat
// enters, so write it only while the block is idle.

module chacha_memtest_pattern_checker import chmt_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [DATA_W-1:0] i_cfg_wdata,
    chmt_in_if.sink           i_in,
    chmt_out_if.source        o_out
);

    logic [DATA_W-1:0]     r_salt;
    t_state                w_init;
    t_side                 w_side_in;
    t_state                w_src   [NUM_STAGES];
    t_state                n_st    [NUM_STAGES];
    t_state                r_st    [NUM_STAGES];
    t_side                 r_side  [NUM_STAGES];
    logic [NUM_STAGES-1:0] r_valid;
    logic                  w_en;

    logic [DATA_W-1:0]     n_pattern;
    logic                  n_mismatch;
    logic                  n_skipped;
    logic [DATA_W-1:0]     r_pattern;
    logic                  r_mismatch;
    logic                  r_skipped;
    logic                  r_out_valid;

    // Salt register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_salt <= '0;
        end else if (i_cfg_we) begin
            r_salt <= i_cfg_wdata;
        end
    end

    // Global advance: move when the output register is empty or being taken
    assign w_en       = !r_out_valid || o_out.ready;
    assign i_in.ready = w_en;

    // Initial state from constants, block number and salt halves
    always_comb begin
        logic [DATA_W-1:0] blk;
        logic [DATA_W-1:0] s1;
        logic [DATA_W-1:0] s2;
        blk = DATA_W'(i_in.block_index);
        s1  = {32'd0, r_salt[31:0]};
        s2  = {32'd0, r_salt[63:32]};
        w_init[0]  = LANE_C0;
        w_init[1]  = LANE_C1;
        w_init[2]  = LANE_C2;
        w_init[3]  = LANE_C3;
        w_init[4]  = LANE_C4;
        w_init[5]  = blk;
        w_init[6]  = s1;
        w_init[7]  = s2;
        w_init[8]  = blk;
        w_init[9]  = s1;
        w_init[10] = s2;
        w_init[11] = blk;
        w_init[12] = s1;
        w_init[13] = s2;
        w_init[14] = blk;
        w_init[15] = s1;
    end

    // Sideband: skip words 0..15 of block 0
    always_comb begin
        w_side_in.action    = i_in.action;
        w_side_in.skip      = (i_in.block_index == '0) &&
                              (i_in.word_index[WORD_W-1:LANE_W] == '0);
        w_side_in.lane      = i_in.word_index[LANE_W-1:0];
        w_side_in.read_data = i_in.read_data;
    end

    // Round pipeline: one add/xor/rotate step per stage
    for (genvar s = 0; s < NUM_STAGES; s++) begin : g_stage
        localparam int unsigned LAYER = s / STEPS_PER_QR;
        localparam int unsigned KK    = s % STEPS_PER_QR;
        localparam logic        DIAG  = 1'((LAYER % 2) == 1);

        if (s == 0) begin : g_first
            assign w_src[s] = w_init;

            // Sideband payload: no reset needed
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_side[s] <= w_side_in;
                end
            end

            // Valid bit enters with the transaction
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_valid[s] <= 1'b0;
                end else if (w_en) begin
                    r_valid[s] <= i_in.valid;
                end
            end
        end else begin : g_next
            assign w_src[s] = r_st[s-1];

            // Sideband payload: no reset needed
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_side[s] <= r_side[s-1];
                end
            end

            // Valid bit travels with the data
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_valid[s] <= 1'b0;
                end else if (w_en) begin
                    r_valid[s] <= r_valid[s-1];
                end
            end
        end

        always_comb begin
            n_st[s] = qr_step(w_src[s], DIAG, KK);
        end

        // State payload: no reset needed
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_st[s] <= n_st[s];
            end
        end
    end

    // Lane select and read-data compare
    always_comb begin
        t_side sd;
        sd = r_side[NUM_STAGES-1];
        if (sd.skip) begin
            n_pattern  = '0;
            n_mismatch = 1'b0;
            n_skipped  = 1'b1;
        end else begin
            n_pattern  = r_st[NUM_STAGES-1][sd.lane];
            n_mismatch = sd.action && (sd.read_data != n_pattern);
            n_skipped  = 1'b0;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pattern  <= n_pattern;
            r_mismatch <= n_mismatch;
            r_skipped  <= n_skipped;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= r_valid[NUM_STAGES-1];
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.pattern_word = r_pattern;
    assign o_out.mismatch     = r_mismatch;
    assign o_out.skipped      = r_skipped;

endmodule
